// ===== rtl/pru_pkg.sv =====
package pru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int MAX_SCALE  = 100;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W      = 24;
    localparam int KIND_W     = 2;
    localparam int SCALE_W    = 7;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic MODE_WRITE = 1'b0;

    // line store access and result of one accepted beat
    typedef struct packed {
        logic              wr_en;
        logic [AW-1:0]     wr_addr;
        logic              rd_en;
        logic [AW-1:0]     rd_addr;
        logic              res_valid;
        logic [KIND_W-1:0] kind;
        logic              row_end;
        logic              image_end;
    } t_req;

endpackage

// ===== rtl/pru_ctrl.sv =====
module pru_ctrl import pru_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_mode,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_req                  o_req
);

    logic [SCALE_W-1:0]  r_scale, n_scale;
    logic [WIDTH_W-1:0]  r_width, n_width;
    logic [HEIGHT_W-1:0] r_height, n_height;

    logic [AW:0]         r_wc, n_wc;
    logic [AW-1:0]       r_col, n_col;
    logic [SCALE_W-1:0]  r_pr, n_pr;
    logic [SCALE_W-1:0]  r_rr, n_rr;
    logic [1:0]          r_pl, n_pl;
    logic                r_inpad, n_inpad;
    logic [ROW_W-1:0]    r_rc, n_rc;

    logic [3:0] w_prod;
    logic [1:0] w_pad;
    logic       w_last_copy;
    logic       w_last_col;
    logic       w_last_rrep;
    logic       w_last_srow;
    logic       w_last_row;
    logic       w_pix_done;
    logic       w_finish;
    logic       w_pad_last;

    // row padding = (3*w*s) mod 4 complement = (w*s) mod 4
    assign w_prod      = {2'b00, r_width[1:0]} * {2'b00, r_scale[1:0]};
    assign w_pad       = w_prod[1:0];
    assign w_last_copy = ({1'b0, r_pr} + 8'd1) >= {1'b0, r_scale};
    assign w_last_col  = ({1'b0, r_col} + 11'd1) >= r_width;
    assign w_last_rrep = ({1'b0, r_rr} + 8'd1) >= {1'b0, r_scale};
    assign w_last_srow = ({1'b0, r_rc} + 13'd1) >= r_height;
    assign w_last_row  = w_last_rrep && w_last_srow;
    assign w_pix_done  = w_last_copy && w_last_col;
    assign w_pad_last  = r_pl <= 2'd1;

    always_comb begin
        n_scale  = r_scale;
        n_width  = r_width;
        n_height = r_height;
        n_wc     = r_wc;
        n_col    = r_col;
        n_pr     = r_pr;
        n_rr     = r_rr;
        n_pl     = r_pl;
        n_inpad  = r_inpad;
        n_rc     = r_rc;
        w_finish = 1'b0;

        o_req           = '0;
        o_req.wr_addr   = r_wc[AW-1:0];
        o_req.rd_addr   = r_col;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE: begin
                    if (i_cfg_data[SCALE_W-1:0] == '0) begin
                        n_scale = SCALE_W'(1);
                    end else if (i_cfg_data[SCALE_W-1:0] > SCALE_W'(MAX_SCALE)) begin
                        n_scale = SCALE_W'(MAX_SCALE);
                    end else begin
                        n_scale = i_cfg_data[SCALE_W-1:0];
                    end
                end
                CFG_WIDTH: begin
                    if (i_cfg_data[WIDTH_W-1:0] == '0) begin
                        n_width = WIDTH_W'(1);
                    end else if (i_cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) begin
                        n_width = WIDTH_W'(MAX_WIDTH);
                    end else begin
                        n_width = i_cfg_data[WIDTH_W-1:0];
                    end
                end
                CFG_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        n_height = HEIGHT_W'(1);
                    end else if (i_cfg_data > HEIGHT_W'(MAX_HEIGHT)) begin
                        n_height = HEIGHT_W'(MAX_HEIGHT);
                    end else begin
                        n_height = i_cfg_data;
                    end
                end
                default: ;
            endcase
            n_wc    = '0;
            n_col   = '0;
            n_pr    = '0;
            n_rr    = '0;
            n_pl    = '0;
            n_inpad = 1'b0;
            n_rc    = '0;
        end else if (i_fire) begin
            if (i_mode == MODE_WRITE) begin
                if (r_wc < r_width) begin
                    o_req.wr_en = 1'b1;
                    n_wc        = r_wc + 1'b1;
                end else begin
                    o_req.res_valid = 1'b1;
                    o_req.kind      = KIND_REJECT;
                end
            end else if (r_inpad) begin
                o_req.res_valid = 1'b1;
                o_req.kind      = KIND_PAD;
                o_req.row_end   = w_pad_last;
                o_req.image_end = w_pad_last && w_last_row;
                if (w_pad_last) begin
                    w_finish = 1'b1;
                end else begin
                    n_pl = r_pl - 2'd1;
                end
            end else if ({1'b0, r_col} >= r_wc) begin
                o_req.res_valid = 1'b1;
                o_req.kind      = KIND_WAIT;
            end else begin
                o_req.res_valid = 1'b1;
                o_req.rd_en     = 1'b1;
                o_req.kind      = KIND_PIXEL;
                o_req.row_end   = w_pix_done && (w_pad == 2'd0);
                o_req.image_end = w_pix_done && (w_pad == 2'd0) && w_last_row;
                if (w_pix_done) begin
                    if (w_pad == 2'd0) begin
                        w_finish = 1'b1;
                    end else begin
                        n_inpad = 1'b1;
                        n_pl    = w_pad;
                    end
                end else if (w_last_copy) begin
                    n_pr  = '0;
                    n_col = r_col + 1'b1;
                end else begin
                    n_pr = r_pr + 1'b1;
                end
            end

            if (w_finish) begin
                n_col   = '0;
                n_pr    = '0;
                n_inpad = 1'b0;
                n_pl    = '0;
                n_rr    = r_rr + 1'b1;
                if (w_last_rrep) begin
                    n_rr = '0;
                    n_wc = '0;
                    n_rc = w_last_srow ? '0 : r_rc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_W'(1);
            r_width  <= WIDTH_W'(1);
            r_height <= HEIGHT_W'(1);
            r_wc     <= '0;
            r_col    <= '0;
            r_pr     <= '0;
            r_rr     <= '0;
            r_pl     <= '0;
            r_inpad  <= 1'b0;
            r_rc     <= '0;
        end else begin
            r_scale  <= n_scale;
            r_width  <= n_width;
            r_height <= n_height;
            r_wc     <= n_wc;
            r_col    <= n_col;
            r_pr     <= n_pr;
            r_rr     <= n_rr;
            r_pl     <= n_pl;
            r_inpad  <= n_inpad;
            r_rc     <= n_rc;
        end
    end

endmodule

// ===== rtl/pixel_replication_upscaler_core.sv =====
// Integer pixel-replication upscaler. A beat with tuser=0 writes the next source
// pixel into a one-row line buffer (1024 x 24-bit synchronous RAM); a beat with
// tuser=1 pulls the next output item: a replicated pixel, a zero padding byte that
// rounds each output row up to a multiple of four bytes, "not ready" when the pull
// runs ahead of written pixels, or "rejected" for a write while the row replays.
// One beat per clock is accepted unless the output stalls; a result passes the line
// buffer read, then the output register. Configuration writes restart the image
// and must be issued while no result is pending. The line buffer needs no clearing.
module pixel_replication_upscaler_core import pru_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // [23:0] pixel
    input  logic                  s_axis_tuser,   // [0] mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // [23:0] pixel_out
    output logic                  m_axis_tlast,   // row_end
    output logic [KIND_W:0]       m_axis_tuser,   // [1:0] kind, [2] image_end
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd;

    t_req w_req;
    logic w_fire;
    logic w_a_adv;

    logic              r_a_v;
    logic [KIND_W-1:0] r_a_kind;
    logic              r_a_re;
    logic              r_a_ie;

    logic              r_b_v;
    logic [PIX_W-1:0]  r_b_pix;
    logic [KIND_W-1:0] r_b_kind;
    logic              r_b_re;
    logic              r_b_ie;

    assign w_a_adv       = r_a_v && (!r_b_v || m_axis_tready);
    assign s_axis_tready = !r_a_v || w_a_adv;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    pru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_mode      (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_req       (w_req)
    );

    always_ff @(posedge i_clk) begin
        if (w_req.wr_en) begin
            r_mem[w_req.wr_addr] <= s_axis_tdata;
        end
        if (w_req.rd_en) begin
            r_rd <= r_mem[w_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_fire) begin
            r_a_v <= w_req.res_valid;
        end else if (w_a_adv) begin
            r_a_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_a_kind <= w_req.kind;
            r_a_re   <= w_req.row_end;
            r_a_ie   <= w_req.image_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_a_adv) begin
            r_b_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_b_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_b_pix  <= (r_a_kind == KIND_PIXEL) ? r_rd : '0;
            r_b_kind <= r_a_kind;
            r_b_re   <= r_a_re;
            r_b_ie   <= r_a_ie;
        end
    end

    assign m_axis_tvalid = r_b_v;
    assign m_axis_tdata  = r_b_pix;
    assign m_axis_tlast  = r_b_re;
    assign m_axis_tuser  = {r_b_ie, r_b_kind};

endmodule

// ===== rtl/pru_checker.sv =====
module pru_checker import pru_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [PIX_W-1:0]      m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic [KIND_W:0]       m_axis_tuser
);

    // only pixel beats carry data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[KIND_W-1:0] != KIND_PIXEL) |-> m_axis_tdata == '0)
        else $error("non-pixel beat with nonzero data");

    a_image_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[KIND_W] |-> m_axis_tlast)
        else $error("image end without row end");

    a_status_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tuser[KIND_W-1:0] == KIND_WAIT)
                       || (m_axis_tuser[KIND_W-1:0] == KIND_REJECT))
        |-> !m_axis_tlast && !m_axis_tuser[KIND_W])
        else $error("status beat carries row or image end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                          && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stalled after reset");

endmodule

bind pixel_replication_upscaler_core pru_checker u_pru_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
